@@ src/dominator_tree_engine_defines.svh @@
// ---------------------------------------------------------------------------
// Dominator tree engine assertion macros
// Shared property forms for the checker; clk and arst_n must be in scope.
// ---------------------------------------------------------------------------
`ifndef DOMINATOR_TREE_ENGINE_DEFINES_SVH
`define DOMINATOR_TREE_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/dte_pkg.sv @@
// ---------------------------------------------------------------------------
// Dominator tree engine package
// Opcodes, status codes, register indexes and the controller state type.
// ---------------------------------------------------------------------------
package dte_pkg;

	localparam int BLK_W = 6;

	localparam logic [2:0] OP_ADD_EDGE  = 3'd0;
	localparam logic [2:0] OP_MARK_DEAD = 3'd1;
	localparam logic [2:0] OP_COMPUTE   = 3'd2;
	localparam logic [2:0] OP_QUERY     = 3'd3;
	localparam logic [2:0] OP_CLEAR     = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_RANGE    = 2'd2;
	localparam logic [1:0] STAT_NO_CONV  = 2'd3;

	localparam logic REG_NUM_BLOCKS  = 1'b0;
	localparam logic REG_ENTRY_BLOCK = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE,
		S_EMIT,
		S_C_PASS,
		S_C_BLK,
		S_C_CNT,
		S_C_PRED,
		S_C_PGOT,
		S_C_WALK,
		S_C_WGOT,
		S_C_FIN,
		S_L_RD,
		S_L_WR,
		S_Q_B,
		S_Q_STEP,
		S_Q_GOT
	} state_t;

endpackage

@@ src/dominator_tree_engine.sv @@
// ---------------------------------------------------------------------------
// Dominator tree engine
// Immediate dominators of a loaded control-flow graph by iterative sweeps.
// ---------------------------------------------------------------------------
// Usage:
// The slave stream carries commands (opcode, first_block, second_block). Add
// edge and mark dead load the graph, compute sweeps all blocks until the idom
// table settles, a sweep bound is hit or a walk breaks, then lists one result
// per block, query walks the idom chain, and clear wipes the graph. Every
// command except the unused opcodes answers on the master stream; tlast marks
// its final result. A query of a block against itself answers without a walk;
// other queries read one idom after another up the chain until it reaches the
// first block, the entry or a block without an idom, or the step bound runs out.
// Compute is bounded by the sweep loop: each sweep reads the predecessor
// count, every predecessor and the idom table per block, and each intersect
// step goes through the single idom table read port.
// A new command is taken only when the previous one has finished; a result
// still waiting in the output register does not hold off that acceptance.
// When the receiver stalls, the list pauses until the output register drains.
// Reset clears counts, dead marks and idom valid flags at once; no clearing
// pass is needed. num_blocks resets to 1 and entry_block to 0.
// ---------------------------------------------------------------------------
module dominator_tree_engine
	import dte_pkg::*;
#(
	parameter int MAX_BLOCKS = 64,
	parameter int MAX_PREDS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[2:0], first_block[8:3], second_block[14:9], zero[15]
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// block_index[5:0], idom_block[11:6], idom_known[12], dominates[13], status[15:14]
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_PREDS + 1);
	localparam int AW = (MAX_BLOCKS * MAX_PREDS > 1) ? $clog2(MAX_BLOCKS * MAX_PREDS) : 1;

	state_t state_q, state_d;

	logic [6:0] num_q;
	logic [5:0] entry_q;
	logic [6:0] n_eff;

	logic [BLK_W-1:0] pred_mem [MAX_BLOCKS*MAX_PREDS];
	logic [CW-1:0]    pc_mem   [MAX_BLOCKS];
	logic [BLK_W-1:0] idom_mem [MAX_BLOCKS];
	logic [BLK_W-1:0] pred_rd;
	logic [CW-1:0]    pc_rd;
	logic [BLK_W-1:0] idom_rd;
	logic [MAX_BLOCKS-1:0] pc_vld_q, dead_q, ivld_q;

	logic [5:0] a_q, b_q;
	logic [6:0] i_q, steps_q;
	logic [7:0] pass_q;
	logic [CW-1:0] k_q, cnt_q;
	logic have_q, changed_q;
	logic [5:0] cand_q, f1_q, f2_q, curr_q;
	logic [1:0] cst_q;
	logic [5:0] r_blk_q, r_idom_q;
	logic r_known_q, r_dom_q;
	logic [1:0] r_st_q;
	logic m_tvalid_q, m_tlast_q;
	logic [15:0] m_tdata_q;

	logic [2:0] in_op;
	logic [5:0] in_a, in_b;
	logic accept, out_free;
	logic ia_bad, ib_bad, entry_bad;
	logic [CW-1:0] edge_cnt;
	logic edge_full, blk_end, blk_skip, p_skip, walk_eq, hi_vld, wgot_over;
	logic fin_upd, list_last, q_stop, pass_over;
	logic [5:0] walk_hi;
	logic [IW-1:0] pc_raddr, idom_raddr, idom_waddr;
	logic [5:0] idom_wdata;
	logic idom_we, pred_we;
	logic [AW-1:0] pred_raddr, pred_waddr;

	function automatic logic [AW-1:0] paddr(input logic [5:0] blk, input logic [CW-1:0] k);
		paddr = AW'(blk[IW-1:0]) * AW'(MAX_PREDS) + AW'(k);
	endfunction

	always_comb begin
		if (num_q == 7'd0) begin
			n_eff = 7'd1;
		end else if (num_q > 7'(MAX_BLOCKS)) begin
			n_eff = 7'(MAX_BLOCKS);
		end else begin
			n_eff = num_q;
		end
	end

	assign in_op     = s_tdata[2:0];
	assign in_a      = s_tdata[8:3];
	assign in_b      = s_tdata[14:9];
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign ia_bad    = {1'b0, in_a} >= n_eff;
	assign ib_bad    = {1'b0, in_b} >= n_eff;
	assign entry_bad = {1'b0, entry_q} >= n_eff;

	assign edge_cnt  = pc_vld_q[b_q[IW-1:0]] ? pc_rd : '0;
	assign edge_full = edge_cnt >= CW'(MAX_PREDS);
	assign blk_end   = (i_q == n_eff);
	assign blk_skip  = (i_q == {1'b0, entry_q}) || dead_q[i_q[IW-1:0]];
	assign p_skip    = ({1'b0, pred_rd} >= n_eff) || !ivld_q[pred_rd[IW-1:0]];
	assign walk_eq   = (f1_q == f2_q);
	assign walk_hi   = (f1_q > f2_q) ? f1_q : f2_q;
	assign hi_vld    = ivld_q[walk_hi[IW-1:0]];
	assign wgot_over = (steps_q + 7'd1) > n_eff;
	assign fin_upd   = have_q && (!ivld_q[i_q[IW-1:0]] || idom_rd != cand_q);
	assign list_last = (i_q + 7'd1) == n_eff;
	assign q_stop    = (curr_q == entry_q) || !ivld_q[curr_q[IW-1:0]];
	assign pass_over = pass_q >= (8'({n_eff, 1'b0}) + 8'd2);

	// Memory addressing.
	assign pc_raddr   = (state_q == S_IDLE) ? in_b[IW-1:0] : i_q[IW-1:0];
	assign pred_raddr = paddr(i_q[5:0], k_q);
	assign pred_waddr = paddr(b_q, edge_cnt);
	assign pred_we    = (state_q == S_EDGE) && !edge_full;

	always_comb begin
		case (state_q)
			S_IDLE:   idom_raddr = in_b[IW-1:0];
			S_C_WALK: idom_raddr = walk_hi[IW-1:0];
			S_Q_STEP: idom_raddr = curr_q[IW-1:0];
			default:  idom_raddr = i_q[IW-1:0];
		endcase
	end

	always_comb begin
		idom_we    = 1'b0;
		idom_waddr = i_q[IW-1:0];
		idom_wdata = cand_q;
		if (accept && in_op == OP_COMPUTE && !entry_bad) begin
			idom_we    = 1'b1;
			idom_waddr = entry_q[IW-1:0];
			idom_wdata = entry_q;
		end else if (state_q == S_C_FIN && fin_upd) begin
			idom_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pred_we) begin
			pred_mem[pred_waddr] <= a_q;
			pc_mem[b_q[IW-1:0]]  <= edge_cnt + CW'(1);
		end
		if (idom_we) begin
			idom_mem[idom_waddr] <= idom_wdata;
		end
		pred_rd <= pred_mem[pred_raddr];
		pc_rd   <= pc_mem[pc_raddr];
		idom_rd <= idom_mem[idom_raddr];
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					case (in_op)
						OP_ADD_EDGE:  state_d = (ia_bad || ib_bad) ? S_EMIT : S_EDGE;
						OP_MARK_DEAD: state_d = S_EMIT;
						OP_COMPUTE:   state_d = entry_bad ? S_EMIT : S_C_PASS;
						OP_QUERY:     state_d = (ia_bad || ib_bad) ? S_EMIT : S_Q_B;
						OP_CLEAR:     state_d = S_EMIT;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_EDGE:   state_d = S_EMIT;
			S_EMIT:   if (out_free) state_d = S_IDLE;
			S_C_PASS: state_d = pass_over ? S_L_RD : S_C_BLK;
			S_C_BLK: begin
				if (blk_end) begin
					state_d = changed_q ? S_C_PASS : S_L_RD;
				end else if (!blk_skip) begin
					state_d = S_C_CNT;
				end
			end
			S_C_CNT:  state_d = S_C_PRED;
			S_C_PRED: state_d = (k_q == cnt_q) ? S_C_FIN : S_C_PGOT;
			S_C_PGOT: state_d = (p_skip || !have_q) ? S_C_PRED : S_C_WALK;
			S_C_WALK: begin
				if (walk_eq) begin
					state_d = S_C_PRED;
				end else begin
					state_d = hi_vld ? S_C_WGOT : S_L_RD;
				end
			end
			S_C_WGOT: state_d = wgot_over ? S_L_RD : S_C_WALK;
			S_C_FIN:  state_d = S_C_BLK;
			S_L_RD:   if (out_free) state_d = S_L_WR;
			S_L_WR:   state_d = list_last ? S_IDLE : S_L_RD;
			S_Q_B:    state_d = (a_q == b_q) ? S_EMIT : S_Q_STEP;
			S_Q_STEP: state_d = q_stop ? S_EMIT : S_Q_GOT;
			S_Q_GOT: begin
				if (idom_rd == a_q || idom_rd == curr_q || wgot_over) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_Q_STEP;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Control state with reset: state, flags, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			num_q      <= 7'd1;
			entry_q    <= 6'd0;
			pc_vld_q   <= '0;
			dead_q     <= '0;
			ivld_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_NUM_BLOCKS:  num_q   <= cfg_data;
					REG_ENTRY_BLOCK: entry_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if ((state_q == S_EMIT && out_free) || state_q == S_L_WR) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				case (in_op)
					OP_MARK_DEAD: if (!ia_bad) dead_q[in_a[IW-1:0]] <= 1'b1;
					OP_COMPUTE: begin
						ivld_q <= entry_bad ? '0 : (MAX_BLOCKS'(1) << entry_q[IW-1:0]);
					end
					OP_CLEAR: begin
						pc_vld_q <= '0;
						dead_q   <= '0;
						ivld_q   <= '0;
					end
					default: ;
				endcase
			end
			if (pred_we) begin
				pc_vld_q[b_q[IW-1:0]] <= 1'b1;
			end
			if (state_q == S_C_FIN && fin_upd) begin
				ivld_q[i_q[IW-1:0]] <= 1'b1;
			end
		end
	end

	// Working registers and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q       <= in_a;
				b_q       <= in_b;
				r_idom_q  <= 6'd0;
				r_known_q <= 1'b0;
				r_dom_q   <= 1'b0;
				pass_q    <= 8'd0;
				case (in_op)
					OP_MARK_DEAD: begin
						r_blk_q <= in_a;
						r_st_q  <= ia_bad ? STAT_RANGE : STAT_OK;
					end
					OP_COMPUTE: begin
						r_blk_q <= 6'd0;
						r_st_q  <= STAT_RANGE;
					end
					OP_CLEAR: begin
						r_blk_q <= 6'd0;
						r_st_q  <= STAT_OK;
					end
					default: begin
						r_blk_q <= in_b;
						r_st_q  <= (ia_bad || ib_bad) ? STAT_RANGE : STAT_OK;
					end
				endcase
			end
			S_EDGE: r_st_q <= edge_full ? STAT_FULL : STAT_OK;
			S_EMIT: begin
				if (out_free) begin
					m_tdata_q <= {r_st_q, r_dom_q, r_known_q, r_idom_q, r_blk_q};
					m_tlast_q <= 1'b1;
				end
			end
			S_C_PASS: begin
				changed_q <= 1'b0;
				i_q       <= 7'd0;
				if (pass_over) cst_q <= STAT_NO_CONV;
			end
			S_C_BLK: begin
				if (blk_end) begin
					pass_q <= pass_q + 8'd1;
					if (!changed_q) begin
						cst_q <= STAT_OK;
						i_q   <= 7'd0;
					end
				end else if (blk_skip) begin
					i_q <= i_q + 7'd1;
				end else begin
					k_q    <= '0;
					have_q <= 1'b0;
				end
			end
			S_C_CNT: cnt_q <= pc_vld_q[i_q[IW-1:0]] ? pc_rd : '0;
			S_C_PGOT: begin
				if (p_skip) begin
					k_q <= k_q + CW'(1);
				end else if (!have_q) begin
					cand_q <= pred_rd;
					have_q <= 1'b1;
					k_q    <= k_q + CW'(1);
				end else begin
					f1_q    <= pred_rd;
					f2_q    <= cand_q;
					steps_q <= 7'd0;
				end
			end
			S_C_WALK: begin
				if (walk_eq) begin
					cand_q <= f1_q;
					k_q    <= k_q + CW'(1);
				end else if (!hi_vld) begin
					cst_q <= STAT_NO_CONV;
					i_q   <= 7'd0;
				end
			end
			S_C_WGOT: begin
				if (wgot_over) begin
					cst_q <= STAT_NO_CONV;
					i_q   <= 7'd0;
				end else begin
					steps_q <= steps_q + 7'd1;
					if (f1_q > f2_q) f1_q <= idom_rd;
					else f2_q <= idom_rd;
				end
			end
			S_C_FIN: begin
				i_q <= i_q + 7'd1;
				if (fin_upd) changed_q <= 1'b1;
			end
			S_L_WR: begin
				m_tdata_q <= {cst_q, 1'b0, ivld_q[i_q[IW-1:0]],
					ivld_q[i_q[IW-1:0]] ? idom_rd : 6'd0, i_q[5:0]};
				m_tlast_q <= list_last;
				i_q       <= i_q + 7'd1;
			end
			S_Q_B: begin
				r_idom_q  <= ivld_q[b_q[IW-1:0]] ? idom_rd : 6'd0;
				r_known_q <= ivld_q[b_q[IW-1:0]];
				r_dom_q   <= (a_q == b_q);
				r_st_q    <= STAT_OK;
				curr_q    <= b_q;
				steps_q   <= 7'd0;
			end
			S_Q_GOT: begin
				if (idom_rd == a_q) begin
					r_dom_q <= 1'b1;
				end else if (idom_rd != curr_q) begin
					if (wgot_over) begin
						r_st_q <= STAT_NO_CONV;
					end else begin
						curr_q  <= idom_rd;
						steps_q <= steps_q + 7'd1;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ src/dte_checker.sv @@
// ---------------------------------------------------------------------------
// Dominator tree engine checker
// Port-level properties of the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "dominator_tree_engine_defines.svh"

module dte_checker
	import dte_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	logic [1:0] res_st;
	logic       res_dom, res_known;
	logic [5:0] res_idom;
	logic       stall, is_range, no_data;

	assign res_st    = m_tdata[15:14];
	assign res_dom   = m_tdata[13];
	assign res_known = m_tdata[12];
	assign res_idom  = m_tdata[11:6];
	assign stall     = m_tvalid && !m_tready;
	assign is_range  = m_tvalid && res_st == STAT_RANGE;
	assign no_data   = !res_dom && !res_known;

	// A stalled result must hold its payload.
	`DTE_ASSERT_NEXT(a_hold, stall, m_tvalid && $stable({m_tlast, m_tdata}), "stalled result changed")

	// A range error never carries an idom or a dominance answer.
	`DTE_ASSERT_IMPL(a_range, is_range, no_data && m_tlast, "range error result carries data")

	// An unknown idom is reported as zero.
	`DTE_ASSERT_IMPL(a_idom0, m_tvalid && !res_known, res_idom == 6'd0, "unknown idom not zero")

	// A positive dominance answer only comes with an ok status.
	`DTE_ASSERT_IMPL(a_dom_ok, m_tvalid && res_dom, res_st == STAT_OK && m_tlast, "dominance, bad status")

endmodule

bind dominator_tree_engine dte_checker u_dte_checker (.*);

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// Dominator tree engine testbench
// Loads random and directed control-flow graphs, computes idoms, queries
// dominance and checks every result against a built-in dominator predictor.
// ---------------------------------------------------------------------------
module testbench;
	import dte_pkg::*;

	localparam int NB = 64;
	localparam int NP = 8;

	typedef struct packed {
		logic [1:0] status;
		logic       dominates;
		logic       idom_known;
		logic [5:0] idom_block;
		logic [5:0] block_index;
		logic       last;
	} dom_result_t;

	typedef struct {
		bit         is_cfg;
		logic       reg_idx;
		logic [6:0] reg_val;
		logic [2:0] opcode;
		logic [5:0] first_block;
		logic [5:0] second_block;
	} cmd_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	logic        cfg_index = 0;
	logic [6:0]  cfg_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	dominator_tree_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	// Predictor state
	logic [6:0] pr_num_blocks = 7'd1;
	logic [5:0] pr_entry = 6'd0;
	logic [5:0] pr_preds [NB*NP];
	logic [3:0] pr_pcount [NB];
	bit         pr_dead [NB];
	logic [5:0] pr_idom [NB];
	bit         pr_ivalid [NB];

	cmd_t        cmd_queue[$];
	dom_result_t expected_results[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          computes_sent = 0;
	int          queries_sent = 0;
	bit          long_quiet = 0;

	function automatic int eff_blocks();
		int n;
		n = pr_num_blocks;
		if (n == 0) n = 1;
		if (n > NB) n = NB;
		return n;
	endfunction

	function automatic void push_res(int blk, int idom, bit known, bit dom, logic [1:0] st,
			bit last);
		dom_result_t r;
		r.block_index = blk[5:0];
		r.idom_block = idom[5:0];
		r.idom_known = known;
		r.dominates = dom;
		r.status = st;
		r.last = last;
		expected_results = {expected_results, r};
	endfunction

	// Moves one finger up the idom table; 0 when the walk is broken or too long.
	function automatic bit step_up(inout int f, inout int steps, input int n);
		if (f >= NB || !pr_ivalid[f]) return 0;
		f = pr_idom[f];
		steps++;
		return steps <= n;
	endfunction

	function automatic logic [1:0] sweep_idoms(int n, int entry);
		bit changed;
		int pass, cnt, cand, p, f1, f2, steps;
		bit have;
		changed = 1;
		for (int i = 0; i < NB; i++) pr_ivalid[i] = 0;
		pr_idom[entry] = entry[5:0];
		pr_ivalid[entry] = 1;
		for (pass = 0; changed; pass++) begin
			if (pass >= 2*n + 2) return STAT_NO_CONV;
			changed = 0;
			for (int i = 0; i < n; i++) begin
				if (i == entry || pr_dead[i]) continue;
				cnt = pr_pcount[i];
				if (cnt > NP) cnt = NP;
				have = 0;
				cand = 0;
				for (int k = 0; k < cnt; k++) begin
					p = pr_preds[i*NP + k];
					if (p >= n || !pr_ivalid[p]) continue;
					if (!have) begin
						cand = p;
						have = 1;
					end else begin
						f1 = p;
						f2 = cand;
						steps = 0;
						while (f1 != f2) begin
							while (f1 > f2)
								if (!step_up(f1, steps, n)) return STAT_NO_CONV;
							while (f2 > f1)
								if (!step_up(f2, steps, n)) return STAT_NO_CONV;
						end
						cand = f1;
					end
				end
				if (have && (!pr_ivalid[i] || pr_idom[i] != cand)) begin
					pr_idom[i] = cand[5:0];
					pr_ivalid[i] = 1;
					changed = 1;
				end
			end
		end
		return STAT_OK;
	endfunction

	function automatic void predict_command(logic [2:0] op, int a, int b);
		int n, entry, curr, steps, parent;
		logic [1:0] st;
		bit dom, v;
		n = eff_blocks();
		entry = pr_entry;
		case (op)
			OP_ADD_EDGE: begin
				if (a >= n || b >= n) push_res(b, 0, 0, 0, STAT_RANGE, 1);
				else if (pr_pcount[b] >= NP) push_res(b, 0, 0, 0, STAT_FULL, 1);
				else begin
					pr_preds[b*NP + pr_pcount[b]] = a[5:0];
					pr_pcount[b]++;
					push_res(b, 0, 0, 0, STAT_OK, 1);
				end
			end
			OP_MARK_DEAD: begin
				if (a >= n) push_res(a, 0, 0, 0, STAT_RANGE, 1);
				else begin
					pr_dead[a] = 1;
					push_res(a, 0, 0, 0, STAT_OK, 1);
				end
			end
			OP_COMPUTE: begin
				if (entry >= n) begin
					for (int i = 0; i < NB; i++) pr_ivalid[i] = 0;
					push_res(0, 0, 0, 0, STAT_RANGE, 1);
				end else begin
					st = sweep_idoms(n, entry);
					for (int i = 0; i < n; i++)
						push_res(i, pr_ivalid[i] ? pr_idom[i] : 0, pr_ivalid[i], 0, st,
							i + 1 == n);
				end
			end
			OP_QUERY: begin
				if (a >= n || b >= n) push_res(b, 0, 0, 0, STAT_RANGE, 1);
				else begin
					v = pr_ivalid[b];
					dom = 0;
					st = STAT_OK;
					curr = b;
					steps = 0;
					if (a == b) dom = 1;
					else begin
						while (curr < NB && curr != entry && pr_ivalid[curr]) begin
							parent = pr_idom[curr];
							if (parent == a) begin
								dom = 1;
								break;
							end
							if (parent == curr) break;
							steps++;
							if (steps > n) begin
								st = STAT_NO_CONV;
								break;
							end
							curr = parent;
						end
					end
					push_res(b, v ? pr_idom[b] : 0, v, dom, st, 1);
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < NB; i++) begin
					pr_pcount[i] = 0;
					pr_dead[i] = 0;
					pr_ivalid[i] = 0;
				end
				push_res(0, 0, 0, 0, STAT_OK, 1);
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_cmd(logic [2:0] op, int a, int b);
		cmd_t c;
		c.is_cfg = 0;
		c.reg_idx = 0;
		c.reg_val = '0;
		c.opcode = op;
		c.first_block = a[5:0];
		c.second_block = b[5:0];
		cmd_queue = {cmd_queue, c};
	endfunction

	function automatic void queue_cfg(logic idx, int val);
		cmd_t c;
		c.is_cfg = 1;
		c.reg_idx = idx;
		c.reg_val = val[6:0];
		c.opcode = '0;
		c.first_block = '0;
		c.second_block = '0;
		cmd_queue = {cmd_queue, c};
	endfunction

	// Builds a well-formed graph of n blocks: each block above 0 takes edges from
	// lower blocks and sometimes a back edge, then computes and queries.
	function automatic void queue_graph(int n, int entry);
		int ne;
		queue_cmd(OP_CLEAR, $urandom, $urandom);
		queue_cfg(REG_NUM_BLOCKS, n);
		queue_cfg(REG_ENTRY_BLOCK, entry);
		for (int i = 1; i < n; i++) begin
			ne = $urandom_range(1, 2);
			for (int k = 0; k < ne; k++)
				queue_cmd(OP_ADD_EDGE, $urandom_range(0, i - 1), i);
			if ($urandom_range(0, 5) == 0)
				queue_cmd(OP_ADD_EDGE, $urandom_range(i, n - 1), i);
			if ($urandom_range(0, 20) == 0)
				queue_cmd(OP_MARK_DEAD, i, $urandom);
		end
		queue_cmd(OP_COMPUTE, $urandom, $urandom);
		for (int k = 0; k < 4; k++)
			queue_cmd(OP_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
	endfunction

	// Driver: configuration writes go out only when nothing is outstanding.
	logic busy_cfg = 0;
	int   cfg_hold = 0;
	always @(posedge clk) begin
		bit wr_en;
		wr_en = 0;
		if (arst_n) begin
			if (s_tvalid && s_tready) items_sent++;
			if (!(s_tvalid && !s_tready)) begin
				if (cmd_queue.size() > 0 && cmd_queue[0].is_cfg) begin
					s_tvalid <= 0;
					if (!(s_tvalid && s_tready) && expected_results.size() == 0) begin
						if (cfg_hold < 8) cfg_hold <= cfg_hold + 1;
						else begin
							cfg_hold <= 0;
							wr_en = 1;
							cfg_index <= cmd_queue[0].reg_idx;
							cfg_data <= cmd_queue[0].reg_val;
							if (cmd_queue[0].reg_idx == REG_NUM_BLOCKS)
								pr_num_blocks = cmd_queue[0].reg_val;
							else pr_entry = cmd_queue[0].reg_val[5:0];
							void'(cmd_queue.pop_front());
						end
					end else cfg_hold <= 0;
				end else if (cmd_queue.size() > 0 && (long_quiet || $urandom_range(0, 99) >= 6))
						begin
					s_tvalid <= 1;
					s_tdata <= {1'b0, cmd_queue[0].second_block, cmd_queue[0].first_block,
						cmd_queue[0].opcode};
					predict_command(cmd_queue[0].opcode, cmd_queue[0].first_block,
						cmd_queue[0].second_block);
					if (cmd_queue[0].opcode == OP_COMPUTE) computes_sent++;
					if (cmd_queue[0].opcode == OP_QUERY) queries_sent++;
					void'(cmd_queue.pop_front());
				end else s_tvalid <= 0;
			end
		end
		cfg_wr_en <= wr_en;
	end

	// Monitor: compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		dom_result_t got, want;
		if (arst_n) begin
			m_tready <= long_quiet || $urandom_range(0, 99) >= 6;
			if (m_tvalid && m_tready) begin
				got = {m_tdata[15:14], m_tdata[13], m_tdata[12], m_tdata[11:6],
					m_tdata[5:0], m_tlast};
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: blk exp %0d got %0d idom exp %0d got %0d",
								want.block_index, got.block_index, want.idom_block,
								got.idom_block);
							$display("  known %b/%b dom %b/%b status %0d/%0d last %b/%b",
								want.idom_known, got.idom_known,
								want.dominates, got.dominates, want.status, got.status,
								want.last, got.last);
						end
					end
				end
			end
		end
	end

	initial begin
		int n;
		for (int i = 0; i < NB; i++) begin
			pr_pcount[i] = 0;
			pr_dead[i] = 0;
			pr_ivalid[i] = 0;
			pr_idom[i] = 0;
		end
		for (int i = 0; i < NB*NP; i++) pr_preds[i] = 0;

		// Directed part: the reset setting, extremes, every opcode and error path.
		queue_cmd(OP_QUERY, 0, 0);
		queue_cmd(OP_COMPUTE, 0, 0);
		queue_cmd(OP_ADD_EDGE, 63, 63);
		queue_cmd(3'd5, 1, 2);
		queue_cmd(3'd7, 63, 63);
		queue_cfg(REG_NUM_BLOCKS, 0);
		queue_cfg(REG_ENTRY_BLOCK, 5);
		queue_cmd(OP_COMPUTE, 0, 0);
		queue_cfg(REG_NUM_BLOCKS, 127);
		queue_cfg(REG_ENTRY_BLOCK, 63);
		queue_cmd(OP_MARK_DEAD, 63, 0);
		queue_cmd(OP_ADD_EDGE, 62, 63);
		for (int k = 0; k < 9; k++) queue_cmd(OP_ADD_EDGE, 0, 1); // fills block 1
		queue_cmd(OP_COMPUTE, 0, 0);
		queue_cmd(OP_QUERY, 63, 62);
		queue_cmd(OP_QUERY, 1, 1);
		queue_cmd(OP_CLEAR, 63, 63);
		// Entry at the top: the numbering rule breaks and the walk stops.
		queue_cfg(REG_NUM_BLOCKS, 4);
		queue_cfg(REG_ENTRY_BLOCK, 3);
		queue_cmd(OP_ADD_EDGE, 3, 1);
		queue_cmd(OP_ADD_EDGE, 3, 2);
		queue_cmd(OP_ADD_EDGE, 1, 0);
		queue_cmd(OP_ADD_EDGE, 2, 0);
		queue_cmd(OP_COMPUTE, 0, 0);
		queue_cmd(OP_QUERY, 3, 0);
		// A stale predecessor left from a larger graph.
		queue_cfg(REG_NUM_BLOCKS, 2);
		queue_cfg(REG_ENTRY_BLOCK, 0);
		queue_cmd(OP_ADD_EDGE, 0, 1);
		queue_cmd(OP_COMPUTE, 0, 0);
		queue_cmd(OP_QUERY, 5, 1);

		// Random part: mostly well-formed graphs, a few at full size, plus noise.
		while (cmd_queue.size() < 480) begin
			if ($urandom_range(0, 9) == 0) n = 64;
			else n = $urandom_range(1, 12);
			queue_graph(n, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, n - 1));
			for (int k = 0; k < 3; k++)
				queue_cmd(3'($urandom_range(0, 7)), $urandom, $urandom);
			if ($urandom_range(0, 3) == 0)
				queue_cmd(OP_COMPUTE, 0, 0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2000) @(posedge clk);
		long_quiet = 1;
		repeat (3000) @(posedge clk);
		long_quiet = 0;
		wait (cmd_queue.size() == 0 && !s_tvalid && expected_results.size() == 0);
		repeat (200) @(posedge clk);
		$display("Sent %0d commands (%0d computes, %0d queries), checked %0d results.",
			items_sent, computes_sent, queries_sent, results_seen);
		if (mismatches == 0 && expected_results.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#8000000;
		$display("FAILURE");
		$finish;
	end

endmodule
